// ----- rtl/vbdf_pkg.sv -----
// shared constants, types and constant-table functions for the brick distance compare
// used by every module of the block; depends on nothing
`default_nettype none

package vbdf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CELLS         = 64;
    localparam int LANES         = 16;
    localparam int PHASES        = CELLS / LANES;
    localparam int PHASE_W       = $clog2(PHASES);
    localparam int LANE_W        = $clog2(LANES);
    localparam int CELL_W        = $clog2(CELLS);
    localparam int D2_N          = 28;
    localparam int D2_W          = 5;
    localparam int TAB_W         = 27;
    localparam int OUT_W         = 22;
    localparam int ST_W          = 2;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    typedef enum logic [ST_W-1:0] {
        ST_VALID = 2'd0,
        ST_INF   = 2'd1,
        ST_UNDEF = 2'd2
    } status_t;

    typedef struct packed {
        logic    valid;
        logic    first;
        logic    last;
        status_t status;
    } ctl_t;

    // squared euclidean distance between two morton-coded cells
    function automatic logic [D2_W-1:0] dist2(input logic [CELL_W-1:0] c,
                                              input logic [CELL_W-1:0] o);
        logic [1:0] cx, cy, cz, ox, oy, oz, dx, dy, dz;
        cx = {c[3], c[0]};
        cy = {c[4], c[1]};
        cz = {c[5], c[2]};
        ox = {o[3], o[0]};
        oy = {o[4], o[1]};
        oz = {o[5], o[2]};
        dx = (cx >= ox) ? cx - ox : ox - cx;
        dy = (cy >= oy) ? cy - oy : oy - cy;
        dz = (cz >= oz) ? cz - oz : oz - cz;
        return D2_W'(dx) * D2_W'(dx) + D2_W'(dy) * D2_W'(dy) + D2_W'(dz) * D2_W'(dz);
    endfunction

    // floor(sqrt(s)) with frac fractional bits, for every squared distance s
    function automatic logic [D2_N-1:0][TAB_W-1:0] sqrt_table(input int frac);
        logic [D2_N-1:0][TAB_W-1:0] tab;
        longint unsigned v, r, t;
        for (int s = 0; s < D2_N; s++)
        begin
            v = longint'(s) << (2 * frac);
            r = 0;
            for (int b = 29; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                begin
                    r = t;
                end
            end
            tab[s] = TAB_W'(r);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/voxel_brick_distance_field_compare.sv -----
// top level of the voxel brick distance field compare
// depends on vbdf_pkg, vbdf_lane, vbdf_merge and vbdf_sqrt
`default_nettype none

// Takes one pair of 4x4x4 occupancy bricks: sixteen lanes each work one cell of both bricks
// per cycle, so a new pair is taken only while idle or in the last of the four passes over
// the 64 cells. The sixteen squared differences are merged and accumulated, then a square
// root pipeline of FRAC_BITS+6 stages gives the norm. Results wait in a 16-entry queue;
// input is also held off while that queue could overflow.
module voxel_brick_distance_field_compare #(
    parameter int FRAC_BITS = vbdf_pkg::FRAC_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // brick_a_low, brick_a_high, brick_b_low, brick_b_high
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // field_difference, two zero bits
    output logic      [23:0]  m_tdata,
    // result_status
    output logic      [1:0]   m_tuser
);

    localparam int W   = FRAC_BITS + 3;
    localparam int SQW = 2 * W;
    localparam int RW  = FRAC_BITS + 6;
    localparam int SW  = 2 * RW;
    localparam int XW  = (RW > vbdf_pkg::OUT_W) ? RW : vbdf_pkg::OUT_W;
    localparam int CW  = vbdf_pkg::FIFO_AW + 1;
    localparam int ENW = vbdf_pkg::OUT_W + vbdf_pkg::ST_W;

    logic [vbdf_pkg::CELLS-1:0]   a_reg, b_reg;
    vbdf_pkg::status_t            status_reg;
    logic [vbdf_pkg::PHASE_W-1:0] phase_reg;
    logic                         active_reg;
    logic                         accept;
    logic [vbdf_pkg::CELLS-1:0]   in_a, in_b;

    vbdf_pkg::ctl_t               lane_ctl, ctl_d1_reg, ctl_d2_reg, merge_ctl, root_ctl;
    logic [vbdf_pkg::LANES-1:0][SQW-1:0] sq;
    logic [SW-1:0]                sum;
    logic [RW-1:0]                root;
    logic [XW-1:0]                root_x;
    logic [vbdf_pkg::OUT_W-1:0]   value;

    logic [ENW-1:0]               mem [vbdf_pkg::FIFO_DEPTH];
    logic [vbdf_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]                count_reg, res_reg, res_next;
    logic                         push, pop;

    assign in_a   = s_tdata[63:0];
    assign in_b   = s_tdata[127:64];
    assign s_tready = (!active_reg || phase_reg == vbdf_pkg::PHASE_W'(vbdf_pkg::PHASES - 1))
                      && res_reg < CW'(vbdf_pkg::FIFO_DEPTH);
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= in_a;
            b_reg <= in_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= '0;
            status_reg <= vbdf_pkg::ST_VALID;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            phase_reg  <= '0;
            if (in_a == '0 && in_b == '0)
            begin
                status_reg <= vbdf_pkg::ST_UNDEF;
            end
            else if (in_a == '0 || in_b == '0)
            begin
                status_reg <= vbdf_pkg::ST_INF;
            end
            else
            begin
                status_reg <= vbdf_pkg::ST_VALID;
            end
        end
        else if (active_reg)
        begin
            phase_reg <= phase_reg + vbdf_pkg::PHASE_W'(1);
            if (phase_reg == vbdf_pkg::PHASE_W'(vbdf_pkg::PHASES - 1))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    assign lane_ctl = '{valid:  active_reg,
                        first:  phase_reg == '0,
                        last:   phase_reg == vbdf_pkg::PHASE_W'(vbdf_pkg::PHASES - 1),
                        status: status_reg};

    for (genvar l = 0; l < vbdf_pkg::LANES; l++)
    begin : g_lane
        vbdf_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .brick_a  (a_reg),
            .brick_b  (b_reg),
            .cell_idx ({phase_reg, vbdf_pkg::LANE_W'(l)}),
            .sq       (sq[l])
        );
    end

    // control follows the two lane register stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d1_reg <= '0;
            ctl_d2_reg <= '0;
        end
        else
        begin
            ctl_d1_reg <= lane_ctl;
            ctl_d2_reg <= ctl_d1_reg;
        end
    end

    vbdf_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .sq      (sq),
        .ctl_in  (ctl_d2_reg),
        .sum     (sum),
        .ctl_out (merge_ctl)
    );

    vbdf_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .rad     (sum),
        .ctl_in  (merge_ctl),
        .root    (root),
        .ctl_out (root_ctl)
    );

    assign root_x = XW'(root);

    always_comb
    begin
        unique case (root_ctl.status)
            vbdf_pkg::ST_VALID:
            begin
                value = (root_x > XW'(vbdf_pkg::OUT_MAX)) ? vbdf_pkg::OUT_MAX
                                                          : vbdf_pkg::OUT_W'(root_x);
            end
            vbdf_pkg::ST_INF:
            begin
                value = vbdf_pkg::OUT_MAX;
            end
            default:
            begin
                value = '0;
            end
        endcase
    end

    // result queue, space reserved at input transfer
    assign push     = root_ctl.valid;
    assign pop      = m_tvalid && m_tready;
    assign res_next = res_reg + CW'(accept) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= {root_ctl.status, value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            res_reg    <= '0;
        end
        else
        begin
            res_reg   <= res_next;
            count_reg <= count_reg + CW'(push) - CW'(pop);
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + vbdf_pkg::FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + vbdf_pkg::FIFO_AW'(1);
            end
        end
    end

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {2'b00, mem[rd_ptr_reg][vbdf_pkg::OUT_W-1:0]};
    assign m_tuser  = mem[rd_ptr_reg][ENW-1:vbdf_pkg::OUT_W];

endmodule

`default_nettype wire

// ----- rtl/vbdf_lane.sv -----
// one lane: nearest occupied cell distance of one cell in both bricks, then squared difference
// uses vbdf_pkg for the distance function and the square-root table; two register stages
`default_nettype none

module vbdf_lane #(
    parameter int FRAC_BITS = vbdf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic [vbdf_pkg::CELLS-1:0]          brick_a,
    input  wire logic [vbdf_pkg::CELLS-1:0]          brick_b,
    input  wire logic [vbdf_pkg::CELL_W-1:0]         cell_idx,
    output logic      [2*(FRAC_BITS+3)-1:0]          sq
);

    localparam int W   = FRAC_BITS + 3;
    localparam int SQW = 2 * W;
    localparam logic [vbdf_pkg::D2_N-1:0][vbdf_pkg::TAB_W-1:0] TAB =
        vbdf_pkg::sqrt_table(FRAC_BITS);

    logic [vbdf_pkg::D2_N-1:0] hit_a, hit_b;
    logic [vbdf_pkg::D2_W-1:0] sa, sb, dd;
    logic [W-1:0]              da_reg, db_reg, diff;
    logic [SQW-1:0]            sq_reg;

    always_comb
    begin
        hit_a = '0;
        hit_b = '0;
        dd    = '0;
        for (int o = 0; o < vbdf_pkg::CELLS; o++)
        begin
            dd = vbdf_pkg::dist2(cell_idx, vbdf_pkg::CELL_W'(o));
            if (brick_a[o])
            begin
                hit_a[dd] = 1'b1;
            end
            if (brick_b[o])
            begin
                hit_b[dd] = 1'b1;
            end
        end
        sa = '0;
        sb = '0;
        for (int i = vbdf_pkg::D2_N - 1; i >= 0; i--)
        begin
            if (hit_a[i])
            begin
                sa = vbdf_pkg::D2_W'(i);
            end
            if (hit_b[i])
            begin
                sb = vbdf_pkg::D2_W'(i);
            end
        end
    end

    assign diff = (da_reg >= db_reg) ? da_reg - db_reg : db_reg - da_reg;

    always_ff @(posedge clk)
    begin
        da_reg <= W'(TAB[sa]);
        db_reg <= W'(TAB[sb]);
        sq_reg <= SQW'(diff) * SQW'(diff);
    end

    assign sq = sq_reg;

endmodule

`default_nettype wire

// ----- rtl/vbdf_merge.sv -----
// merging stage: adds the lane squares and accumulates the four phases of one brick pair
// uses vbdf_pkg for lane count and the control struct; two register stages
`default_nettype none

module vbdf_merge #(
    parameter int FRAC_BITS = vbdf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic [vbdf_pkg::LANES-1:0][2*(FRAC_BITS+3)-1:0] sq,
    input  wire vbdf_pkg::ctl_t                                  ctl_in,
    output logic      [2*(FRAC_BITS+6)-1:0]                      sum,
    output vbdf_pkg::ctl_t                                       ctl_out
);

    localparam int SW   = 2 * (FRAC_BITS + 6);
    localparam int GRPS = vbdf_pkg::LANES / 4;

    logic [GRPS-1:0][SW-1:0] grp_reg;
    logic [SW-1:0]           acc_reg, acc_next, grp_total;
    vbdf_pkg::ctl_t          ctl_a_reg, ctl_b_reg;

    always_comb
    begin
        grp_total = '0;
        for (int g = 0; g < GRPS; g++)
        begin
            grp_total = grp_total + grp_reg[g];
        end
        acc_next = (ctl_a_reg.first ? '0 : acc_reg) + grp_total;
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < GRPS; g++)
        begin
            grp_reg[g] <= SW'(sq[4*g]) + SW'(sq[4*g+1]) + SW'(sq[4*g+2]) + SW'(sq[4*g+3]);
        end
        if (ctl_a_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    assign sum     = acc_reg;
    assign ctl_out = '{valid:  ctl_b_reg.valid & ctl_b_reg.last,
                       first:  ctl_b_reg.first,
                       last:   ctl_b_reg.last,
                       status: ctl_b_reg.status};

endmodule

`default_nettype wire

// ----- rtl/vbdf_sqrt.sv -----
// pipelined integer square root, one result bit per stage
// uses vbdf_pkg for the control struct carried beside the data
`default_nettype none

module vbdf_sqrt #(
    parameter int FRAC_BITS = vbdf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [2*(FRAC_BITS+6)-1:0]     rad,
    input  wire vbdf_pkg::ctl_t                 ctl_in,
    output logic      [FRAC_BITS+5:0]           root,
    output vbdf_pkg::ctl_t                      ctl_out
);

    localparam int RW   = FRAC_BITS + 6;
    localparam int SW   = 2 * RW;
    localparam int REMW = RW + 3;

    logic [REMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [SW-1:0]   rad_reg  [RW];
    vbdf_pkg::ctl_t  ctl_reg  [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [REMW-1:0] rem_prev, rem_sh, test;
        logic [RW-1:0]   root_prev;
        logic [SW-1:0]   rad_prev;
        vbdf_pkg::ctl_t  ctl_prev;
        logic            ge;

        if (i == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
            assign ctl_prev  = ctl_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign rad_prev  = rad_reg[i-1];
            assign ctl_prev  = ctl_reg[i-1];
        end

        assign rem_sh = {rem_prev[RW:0], rad_prev[SW-1 -: 2]};
        assign test   = {1'b0, root_prev, 2'b01};
        assign ge     = rem_sh >= test;

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? rem_sh - test : rem_sh;
            root_reg[i] <= {root_prev[RW-2:0], ge};
            rad_reg[i]  <= {rad_prev[SW-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else
            begin
                ctl_reg[i] <= ctl_prev;
            end
        end
    end

    assign root    = root_reg[RW-1];
    assign ctl_out = ctl_reg[RW-1];

endmodule

`default_nettype wire
